@@ design/mid_pkg.sv @@
// Shared types, codes and opcode tables for the MIPS instruction decoder.
`default_nettype none

package mid_pkg;

  // Input item: instruction address and raw word.
  typedef struct packed {
    logic [31:0] instr_pc;
    logic [31:0] instr_word;
  } mid_in_t;

  // Result item.
  typedef struct packed {
    logic               known;
    logic [6:0]         mnemonic;
    logic [3:0]         operand_format;
    logic [4:0]         src_reg;
    logic [4:0]         tgt_reg;
    logic [4:0]         dst_reg;
    logic [4:0]         shift_amount;
    logic signed [15:0] immediate;
    logic               has_target;
    logic [31:0]        target_addr;
  } mid_out_t;

  // Table lookup result.
  typedef struct packed {
    logic       known;
    logic [6:0] mnemonic;
    logic [3:0] fmt;
  } mid_hit_t;

  // Operand format classes.
  localparam logic [3:0] FMT_REG_DST    = 4'd0;  // d,s,t
  localparam logic [3:0] FMT_REG_ST     = 4'd1;  // s,t
  localparam logic [3:0] FMT_REG_DS     = 4'd2;  // d,s
  localparam logic [3:0] FMT_REG_D      = 4'd3;
  localparam logic [3:0] FMT_REG_S      = 4'd4;
  localparam logic [3:0] FMT_SHIFT      = 4'd5;  // d,t,sa
  localparam logic [3:0] FMT_BRANCH_S   = 4'd6;
  localparam logic [3:0] FMT_BRANCH_ST  = 4'd7;
  localparam logic [3:0] FMT_JUMP       = 4'd8;
  localparam logic [3:0] FMT_ARITH_TS   = 4'd9;
  localparam logic [3:0] FMT_LOGIC_T    = 4'd10;
  localparam logic [3:0] FMT_LOGIC_TS   = 4'd11;
  localparam logic [3:0] FMT_MEMORY     = 4'd12;

  // Primary opcodes and function codes that steer the decode.
  localparam logic [5:0] OPC_RTYPE  = 6'h00;
  localparam logic [5:0] OPC_BCOND  = 6'h01;
  localparam logic [5:0] OPC_RTYPE2 = 6'h1C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] FN_OR      = 6'h25;

  // Alias mnemonics.
  localparam logic [6:0] MN_NOP  = 7'd105;
  localparam logic [6:0] MN_MOVE = 7'd106;
  localparam logic [6:0] MN_LI   = 7'd107;

  localparam mid_hit_t HIT_NONE = '{known: 1'b0, mnemonic: 7'd0, fmt: FMT_REG_DST};

  function automatic mid_hit_t mk_hit(input logic [6:0] mn, input logic [3:0] fmt);
    mid_hit_t h;
    h.known    = 1'b1;
    h.mnemonic = mn;
    h.fmt      = fmt;
    return h;
  endfunction

  // SPECIAL group, keyed by funct.
  function automatic mid_hit_t special_lookup(input logic [5:0] fn);
    mid_hit_t h;
    unique case (fn)
      6'h00: h = mk_hit(7'd0,  FMT_SHIFT);
      6'h02: h = mk_hit(7'd1,  FMT_SHIFT);
      6'h03: h = mk_hit(7'd2,  FMT_SHIFT);
      6'h04: h = mk_hit(7'd3,  FMT_REG_DST);
      6'h06: h = mk_hit(7'd4,  FMT_REG_DST);
      6'h07: h = mk_hit(7'd5,  FMT_REG_DST);
      6'h08: h = mk_hit(7'd6,  FMT_REG_S);
      6'h09: h = mk_hit(7'd7,  FMT_REG_DS);
      6'h0A: h = mk_hit(7'd8,  FMT_REG_DST);
      6'h0B: h = mk_hit(7'd9,  FMT_REG_DST);
      6'h10: h = mk_hit(7'd10, FMT_REG_D);
      6'h11: h = mk_hit(7'd11, FMT_REG_S);
      6'h12: h = mk_hit(7'd12, FMT_REG_D);
      6'h13: h = mk_hit(7'd13, FMT_REG_S);
      6'h14: h = mk_hit(7'd14, FMT_REG_DST);
      6'h16: h = mk_hit(7'd15, FMT_REG_DST);
      6'h17: h = mk_hit(7'd16, FMT_REG_DST);
      6'h18: h = mk_hit(7'd17, FMT_REG_ST);
      6'h19: h = mk_hit(7'd18, FMT_REG_ST);
      6'h1A: h = mk_hit(7'd19, FMT_REG_ST);
      6'h1B: h = mk_hit(7'd20, FMT_REG_ST);
      6'h1C: h = mk_hit(7'd21, FMT_REG_ST);
      6'h1D: h = mk_hit(7'd22, FMT_REG_ST);
      6'h1E: h = mk_hit(7'd23, FMT_REG_ST);
      6'h1F: h = mk_hit(7'd24, FMT_REG_ST);
      6'h20: h = mk_hit(7'd25, FMT_REG_DST);
      6'h21: h = mk_hit(7'd26, FMT_REG_DST);
      6'h22: h = mk_hit(7'd27, FMT_REG_DST);
      6'h23: h = mk_hit(7'd28, FMT_REG_DST);
      6'h24: h = mk_hit(7'd29, FMT_REG_DST);
      6'h25: h = mk_hit(7'd30, FMT_REG_DST);
      6'h26: h = mk_hit(7'd31, FMT_REG_DST);
      6'h27: h = mk_hit(7'd32, FMT_REG_DST);
      6'h2A: h = mk_hit(7'd33, FMT_REG_DST);
      6'h2B: h = mk_hit(7'd34, FMT_REG_DST);
      6'h2C: h = mk_hit(7'd35, FMT_REG_DST);
      6'h2D: h = mk_hit(7'd36, FMT_REG_DST);
      6'h2E: h = mk_hit(7'd37, FMT_REG_DST);
      6'h2F: h = mk_hit(7'd38, FMT_REG_DST);
      6'h38: h = mk_hit(7'd39, FMT_SHIFT);
      6'h3A: h = mk_hit(7'd40, FMT_SHIFT);
      6'h3B: h = mk_hit(7'd41, FMT_SHIFT);
      6'h3C: h = mk_hit(7'd42, FMT_SHIFT);
      6'h3E: h = mk_hit(7'd43, FMT_SHIFT);
      6'h3F: h = mk_hit(7'd44, FMT_SHIFT);
      default: h = HIT_NONE;
    endcase
    return h;
  endfunction

  // SPECIAL2 group, keyed by funct.
  function automatic mid_hit_t special2_lookup(input logic [5:0] fn);
    mid_hit_t h;
    unique case (fn)
      6'h00: h = mk_hit(7'd45, FMT_REG_ST);
      6'h01: h = mk_hit(7'd46, FMT_REG_ST);
      6'h02: h = mk_hit(7'd47, FMT_REG_ST);
      6'h04: h = mk_hit(7'd48, FMT_REG_ST);
      6'h05: h = mk_hit(7'd49, FMT_REG_ST);
      6'h20: h = mk_hit(7'd50, FMT_REG_DS);
      6'h21: h = mk_hit(7'd51, FMT_REG_DS);
      6'h24: h = mk_hit(7'd52, FMT_REG_DS);
      6'h25: h = mk_hit(7'd53, FMT_REG_DS);
      default: h = HIT_NONE;
    endcase
    return h;
  endfunction

  // REGIMM group, keyed by the rt field.
  function automatic mid_hit_t regimm_lookup(input logic [4:0] rt);
    mid_hit_t h;
    unique case (rt)
      5'h00: h = mk_hit(7'd54, FMT_BRANCH_S);
      5'h01: h = mk_hit(7'd55, FMT_BRANCH_S);
      5'h02: h = mk_hit(7'd56, FMT_BRANCH_S);
      5'h03: h = mk_hit(7'd57, FMT_BRANCH_S);
      5'h10: h = mk_hit(7'd58, FMT_BRANCH_S);
      5'h11: h = mk_hit(7'd59, FMT_BRANCH_S);
      5'h12: h = mk_hit(7'd60, FMT_BRANCH_S);
      5'h13: h = mk_hit(7'd61, FMT_BRANCH_S);
      default: h = HIT_NONE;
    endcase
    return h;
  endfunction

  // Primary opcode group.
  function automatic mid_hit_t primary_lookup(input logic [5:0] op);
    mid_hit_t h;
    unique case (op)
      6'h02: h = mk_hit(7'd62,  FMT_JUMP);
      6'h03: h = mk_hit(7'd63,  FMT_JUMP);
      6'h04: h = mk_hit(7'd64,  FMT_BRANCH_ST);
      6'h05: h = mk_hit(7'd65,  FMT_BRANCH_ST);
      6'h06: h = mk_hit(7'd66,  FMT_BRANCH_S);
      6'h07: h = mk_hit(7'd67,  FMT_BRANCH_S);
      6'h08: h = mk_hit(7'd68,  FMT_ARITH_TS);
      6'h09: h = mk_hit(7'd69,  FMT_ARITH_TS);
      6'h0A: h = mk_hit(7'd70,  FMT_ARITH_TS);
      6'h0B: h = mk_hit(7'd71,  FMT_ARITH_TS);
      6'h0C: h = mk_hit(7'd72,  FMT_LOGIC_TS);
      6'h0D: h = mk_hit(7'd73,  FMT_LOGIC_TS);
      6'h0E: h = mk_hit(7'd74,  FMT_LOGIC_TS);
      6'h0F: h = mk_hit(7'd75,  FMT_LOGIC_T);
      6'h14: h = mk_hit(7'd76,  FMT_BRANCH_ST);
      6'h15: h = mk_hit(7'd77,  FMT_BRANCH_ST);
      6'h16: h = mk_hit(7'd78,  FMT_BRANCH_S);
      6'h17: h = mk_hit(7'd79,  FMT_BRANCH_S);
      6'h18: h = mk_hit(7'd80,  FMT_ARITH_TS);
      6'h19: h = mk_hit(7'd81,  FMT_ARITH_TS);
      6'h1A: h = mk_hit(7'd82,  FMT_MEMORY);
      6'h1B: h = mk_hit(7'd83,  FMT_MEMORY);
      6'h20: h = mk_hit(7'd84,  FMT_MEMORY);
      6'h21: h = mk_hit(7'd85,  FMT_MEMORY);
      6'h22: h = mk_hit(7'd86,  FMT_MEMORY);
      6'h23: h = mk_hit(7'd87,  FMT_MEMORY);
      6'h24: h = mk_hit(7'd88,  FMT_MEMORY);
      6'h25: h = mk_hit(7'd89,  FMT_MEMORY);
      6'h26: h = mk_hit(7'd90,  FMT_MEMORY);
      6'h27: h = mk_hit(7'd91,  FMT_MEMORY);
      6'h28: h = mk_hit(7'd92,  FMT_MEMORY);
      6'h29: h = mk_hit(7'd93,  FMT_MEMORY);
      6'h2A: h = mk_hit(7'd94,  FMT_MEMORY);
      6'h2B: h = mk_hit(7'd95,  FMT_MEMORY);
      6'h2C: h = mk_hit(7'd96,  FMT_MEMORY);
      6'h2D: h = mk_hit(7'd97,  FMT_MEMORY);
      6'h2E: h = mk_hit(7'd98,  FMT_MEMORY);
      6'h30: h = mk_hit(7'd99,  FMT_MEMORY);
      6'h34: h = mk_hit(7'd100, FMT_MEMORY);
      6'h37: h = mk_hit(7'd101, FMT_MEMORY);
      6'h38: h = mk_hit(7'd102, FMT_MEMORY);
      6'h3C: h = mk_hit(7'd103, FMT_MEMORY);
      6'h3F: h = mk_hit(7'd104, FMT_MEMORY);
      default: h = HIT_NONE;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

@@ design/mips_instruction_decoder.sv @@
// Top level of the MIPS instruction decoder: input register, decode, result register.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid / in_ready  | mid_in_t  (instr_pc, instr_word)
//   out     | output    | out_valid / out_ready| mid_out_t (decoded fields, target)
//
// One instruction per cycle while out_ready is held high; a transfer lands in the
// input register and is decoded from there into the result register.
// The table lookup and the branch-target sum sit between the two registers.
// Reset (rst_n low, synchronous) empties both stages; payload is not cleared.
// A stall on out_ready holds the result register; the input register still
// takes a transfer while it is empty, so a full stall blocks once both hold an item.
`default_nettype none

module mips_instruction_decoder import mid_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,

  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire mid_in_t  in_data,

  output logic          out_valid,
  input  wire logic     out_ready,
  output mid_out_t      out_data
);

  // Input stage.
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  mid_in_t  s1_data_r;

  // Result stage.
  logic     out_valid_r;
  logic     out_valid_nxt;
  mid_out_t out_data_r;

  mid_out_t dec_result;
  logic     in_xfer;
  logic     s1_adv;

  // Result register can load whenever it is empty or being drained.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  mid_decode u_decode (
    .item   (s1_data_r),
    .result (dec_result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: capture on transfer, advance only when the next stage frees up.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= dec_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stalled input stage keeps its item.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("input stage dropped a stalled item");

  // An accepted transfer always occupies the input stage next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted transfer not held in input stage");

  // Unknown words carry no mnemonic or target.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.known |->
      (out_data_r.mnemonic == 7'd0 && !out_data_r.has_target &&
       out_data_r.target_addr == 32'd0))
    else $error("unknown word with decoded fields");

  // Targets appear only for branch and jump formats.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.has_target |->
      (out_data_r.operand_format == FMT_BRANCH_S ||
       out_data_r.operand_format == FMT_BRANCH_ST ||
       out_data_r.operand_format == FMT_JUMP))
    else $error("target flagged on non-branch format");

  // Reset empties the result stage.
  assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule

`default_nettype wire

@@ design/mid_decode.sv @@
// Combinational decode of one instruction word into a result item.
`default_nettype none

module mid_decode import mid_pkg::*; (
  input  wire mid_in_t item,
  output mid_out_t     result
);

  logic [31:0] w;
  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  mid_hit_t    hit;
  logic [6:0]  mn;
  logic [31:0] br_off;
  logic [31:0] br_tgt;
  logic [31:0] j_tgt;
  logic        is_branch;
  logic        is_jump;

  assign w   = item.instr_word;
  assign opc = w[31:26];
  assign fn  = w[5:0];
  assign rs  = w[25:21];
  assign rt  = w[20:16];

  // Select the opcode group, then look up the entry.
  always_comb begin
    unique case (opc)
      OPC_RTYPE:  hit = special_lookup(fn);
      OPC_RTYPE2: hit = special2_lookup(fn);
      OPC_BCOND:  hit = regimm_lookup(rt);
      default:    hit = primary_lookup(opc);
    endcase
  end

  // Alias override.
  always_comb begin
    mn = hit.mnemonic;
    if (hit.fmt == FMT_REG_DST && fn == FN_OR && rt == 5'd0) begin
      mn = MN_MOVE;
    end else if (hit.fmt == FMT_SHIFT && w == 32'd0) begin
      mn = MN_NOP;
    end else if (hit.fmt == FMT_LOGIC_TS && opc == OP_ORI && rs == 5'd0) begin
      mn = MN_LI;
    end
  end

  assign br_off    = {{14{w[15]}}, w[15:0], 2'b00};
  assign br_tgt    = item.instr_pc + 32'd4 + br_off;
  assign j_tgt     = {item.instr_pc[31:28], w[25:0], 2'b00};
  assign is_branch = hit.known && (hit.fmt == FMT_BRANCH_S || hit.fmt == FMT_BRANCH_ST);
  assign is_jump   = hit.known && hit.fmt == FMT_JUMP;

  always_comb begin
    result.known          = hit.known;
    result.mnemonic       = hit.known ? mn : 7'd0;
    result.operand_format = hit.known ? hit.fmt : FMT_REG_DST;
    result.src_reg        = rs;
    result.tgt_reg        = rt;
    result.dst_reg        = w[15:11];
    result.shift_amount   = w[10:6];
    result.immediate      = $signed(w[15:0]);
    result.has_target     = is_branch || is_jump;
    result.target_addr    = is_branch ? br_tgt : (is_jump ? j_tgt : 32'd0);
  end

endmodule

`default_nettype wire
